[src/adc_settled_channel_sampler_defines.svh]
// assertion macros for the settled channel sampler
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef ADC_SETTLED_CHANNEL_SAMPLER_DEFINES_SVH
`define ADC_SETTLED_CHANNEL_SAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ACS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define ACS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ACS_ASSERT_ALWAYS(label, expr, msg)
`define ACS_ASSERT_IMPLIES(label, ante, cons, msg)
`define ACS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[src/acs_pkg.sv]
// shared types, codes and constants for the settled channel sampler
// no dependencies; imported by every other rtl file
`default_nettype none

package acs_pkg;

   localparam int NUM_CHANNELS_DEF = 10;
   localparam int SAMPLE_BITS      = 12;

   localparam int ACTION_W  = 2;
   localparam int CHANNEL_W = 4;
   localparam int CONV_W    = 12;
   localparam int MUX_W     = 5;
   localparam int READ_W    = 12;
   localparam int COUNT_W   = 5;

   // stored and summed sample width: converter field masked to the sample size
   localparam int SAMPLE_W = (SAMPLE_BITS < CONV_W) ? SAMPLE_BITS : CONV_W;
   localparam int SUM_W    = SAMPLE_W + 5;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam int DISCARD_W   = 4;
   localparam int SHIFT_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISCARD_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_SHIFT = 1'b1;

   localparam logic [DISCARD_W-1:0] DISCARD_RESET = 4'd4;
   localparam logic [SHIFT_W-1:0]   SHIFT_RESET   = 3'd2;
   localparam logic [SHIFT_W-1:0]   MAX_SHIFT     = 3'd4;
   localparam logic [MUX_W-1:0]     PARK_INPUT    = 5'd17;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SAMPLE     = 2'd0,
      ACT_CONVERSION = 2'd1,
      ACT_READ       = 2'd2
   } action_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [CHANNEL_W-1:0] channel;
      logic [CONV_W-1:0]    conversion_value;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   // logical channel to converter input
   function automatic logic [MUX_W-1:0] mux_map(input logic [CHANNEL_W-1:0] ch);
      logic [MUX_W-1:0] m;
      case (ch)
         4'd0:    m = 5'd0;
         4'd1:    m = 5'd1;
         4'd2:    m = 5'd5;
         4'd3:    m = 5'd6;
         4'd4:    m = 5'd8;
         4'd5:    m = 5'd9;
         4'd6:    m = 5'd7;
         4'd7:    m = 5'd13;
         4'd8:    m = 5'd14;
         4'd9:    m = 5'd15;
         default: m = 5'd0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

[src/acs_if.sv]
// request and response channel interfaces of the settled channel sampler
// depends on acs_pkg for field widths
`default_nettype none

interface acs_req_if
   import acs_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [CHANNEL_W-1:0] channel;
   logic [CONV_W-1:0]    conversion_value;

   modport source (output valid, action, channel, conversion_value, input ready);
   modport sink   (input valid, action, channel, conversion_value, output ready);
endinterface

interface acs_rsp_if
   import acs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              start_conversion;
   logic [MUX_W-1:0]  mux_channel;
   logic              long_sample_time;
   logic [READ_W-1:0] read_data;
   logic              data_ready;
   logic              busy_res;

   modport source (output valid, start_conversion, mux_channel, long_sample_time,
                   read_data, data_ready, busy_res, input ready);
   modport sink   (input valid, start_conversion, mux_channel, long_sample_time,
                   read_data, data_ready, busy_res, output ready);
endinterface

`default_nettype wire

[src/adc_settled_channel_sampler.sv]
// Settled channel sampler: sequences an external converter for one logical
// channel at a time and keeps an averaged result per channel.
// req_chan carries transactions: a sample request, a conversion-finished event
// with the raw converter value, or a read of a stored channel result.
// rsp_chan returns exactly one transaction per request transaction, carrying
// start_conversion, the mux input, the sample time select, read data and the
// ready/busy status after that event.
// csr_* writes discard_count (index 0) and average_shift (index 1); always ready.
// A request passes the input register, then the response register, before
// response valid. Throughput: one transaction per cycle while rsp_chan.ready
// is high.
// Reset (synchronous) clears the sequencing state, the whole result store and
// both registers' pipeline valids; the configuration returns to 4 and 2.
// When rsp_chan.ready is low the response register holds, the input register
// still takes one more transaction, and req_chan.ready then drops until the
// response is taken.
// depends on acs_pkg, acs_if, acs_in_stage and acs_core
`default_nettype none

module adc_settled_channel_sampler
   import acs_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   acs_req_if.sink                     req_chan,
   acs_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   stage_type stage;
   logic      take;

   acs_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   acs_core #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .take      (take),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

[src/acs_in_stage.sv]
// input register of the sampler: captures one request transaction
// depends on acs_pkg and acs_req_if
`default_nettype none

module acs_in_stage
   import acs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   acs_req_if.sink    req_chan,
   input  wire logic  take,
   output stage_type  stage
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign req_chan.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_chan.ready) begin
         valid_in = req_chan.valid;
         item_in  = '{action:           req_chan.action,
                      channel:          req_chan.channel,
                      conversion_value: req_chan.conversion_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage = '{valid: valid_ff, item: item_ff};

endmodule

`default_nettype wire

[src/acs_core.sv]
// sequencing state, averaging, result store and response register
// depends on acs_pkg, acs_rsp_if and the assertion macro header
`default_nettype none
`include "adc_settled_channel_sampler_defines.svh"

module acs_core
   import acs_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire stage_type              stage,
   output logic                        take,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   acs_rsp_if.source                   rsp_chan
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CHANNEL_W:0] NUM_CH = (CHANNEL_W + 1)'(NUM_CHANNELS);

   logic [DISCARD_W-1:0] discard_count_ff, discard_count_in;
   logic [SHIFT_W-1:0]   average_shift_ff, average_shift_in;

   logic                 busy_ff, busy_in;
   logic                 stable_ff, stable_in;
   logic                 ready_ff, ready_in;
   logic [COUNT_W-1:0]   phase_counter_ff, phase_counter_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CHANNEL_W-1:0] active_ff, active_in;

   logic [SAMPLE_W-1:0] store_ff [NUM_CHANNELS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              start_ff, start_in;
   logic [MUX_W-1:0]  mux_ff, mux_in;
   logic              long_ff, long_in;
   logic [READ_W-1:0] rdata_ff, rdata_in;
   logic              data_ready_ff, data_ready_in;
   logic              busy_res_ff, busy_res_in;

   logic                 store_we;
   logic [SAMPLE_W-1:0]  store_wdata;
   logic                 ch_ok;
   logic [DISCARD_W-1:0] limit;
   logic [SHIFT_W-1:0]   sh;
   logic [COUNT_W-1:0]   count;
   logic [COUNT_W-1:0]   cnt_inc;
   logic [SUM_W-1:0]     sum_new;
   logic [SUM_W-1:0]     sum_round;
   logic [SUM_W-1:0]     avg_full;

   assign take      = stage.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_ready = 1'b1;

   always_comb begin
      discard_count_in = discard_count_ff;
      average_shift_in = average_shift_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DISCARD_COUNT: discard_count_in = csr_data[DISCARD_W-1:0];
            CSR_AVERAGE_SHIFT: average_shift_in = csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   assign ch_ok     = {1'b0, stage.item.channel} < NUM_CH;
   assign limit     = (discard_count_ff == '0) ? DISCARD_W'(1) : discard_count_ff;
   assign sh        = (average_shift_ff > MAX_SHIFT) ? MAX_SHIFT : average_shift_ff;
   assign count     = COUNT_W'(1) << sh;
   assign cnt_inc   = phase_counter_ff + COUNT_W'(1);
   assign sum_new   = sum_ff + SUM_W'(stage.item.conversion_value[SAMPLE_W-1:0]);
   assign sum_round = sum_new + SUM_W'(count >> 1);
   assign avg_full  = sum_round >> sh;

   always_comb begin
      busy_in          = busy_ff;
      stable_in        = stable_ff;
      ready_in         = ready_ff;
      phase_counter_in = phase_counter_ff;
      sum_in           = sum_ff;
      active_in        = active_ff;
      store_we         = 1'b0;
      store_wdata      = avg_full[SAMPLE_W-1:0];
      start_in         = 1'b0;
      rdata_in         = '0;
      case (stage.item.action)
         ACT_SAMPLE: begin
            if (!busy_ff && ch_ok) begin
               busy_in          = 1'b1;
               ready_in         = 1'b0;
               stable_in        = 1'b0;
               phase_counter_in = '0;
               sum_in           = '0;
               active_in        = stage.item.channel;
               start_in         = 1'b1;
            end
         end
         ACT_CONVERSION: begin
            if (busy_ff) begin
               if (!stable_ff) begin
                  start_in = 1'b1;
                  if (cnt_inc >= COUNT_W'(limit)) begin
                     stable_in        = 1'b1;
                     phase_counter_in = '0;
                  end else begin
                     phase_counter_in = cnt_inc;
                  end
               end else if (cnt_inc >= count) begin
                  // last stable conversion: round, store and park
                  store_we         = 1'b1;
                  busy_in          = 1'b0;
                  stable_in        = 1'b0;
                  phase_counter_in = '0;
                  sum_in           = '0;
                  ready_in         = 1'b1;
               end else begin
                  sum_in           = sum_new;
                  phase_counter_in = cnt_inc;
                  start_in         = 1'b1;
               end
            end
         end
         ACT_READ: begin
            if (ch_ok) begin
               rdata_in = READ_W'(store_ff[stage.item.channel[IDX_W-1:0]]);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      mux_in        = mux_ff;
      long_in       = long_ff;
      data_ready_in = data_ready_ff;
      busy_res_in   = busy_res_ff;
      if (take) begin
         rsp_valid_in  = 1'b1;
         mux_in        = busy_in ? mux_map(active_in) : PARK_INPUT;
         long_in       = busy_in ? stable_in : 1'b1;
         data_ready_in = ready_in;
         busy_res_in   = busy_in;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_count_ff <= DISCARD_RESET;
         average_shift_ff <= SHIFT_RESET;
         busy_ff          <= 1'b0;
         stable_ff        <= 1'b0;
         ready_ff         <= 1'b0;
         phase_counter_ff <= '0;
         sum_ff           <= '0;
         active_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         discard_count_ff <= discard_count_in;
         average_shift_ff <= average_shift_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (take) begin
            busy_ff          <= busy_in;
            stable_ff        <= stable_in;
            ready_ff         <= ready_in;
            phase_counter_ff <= phase_counter_in;
            sum_ff           <= sum_in;
            active_ff        <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            store_ff[i] <= '0;
         end
      end else if (take && store_we) begin
         store_ff[active_ff[IDX_W-1:0]] <= store_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         start_ff <= start_in;
         rdata_ff <= rdata_in;
      end
      mux_ff        <= mux_in;
      long_ff       <= long_in;
      data_ready_ff <= data_ready_in;
      busy_res_ff   <= busy_res_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.start_conversion = start_ff;
   assign rsp_chan.mux_channel      = mux_ff;
   assign rsp_chan.long_sample_time = long_ff;
   assign rsp_chan.read_data        = rdata_ff;
   assign rsp_chan.data_ready       = data_ready_ff;
   assign rsp_chan.busy_res         = busy_res_ff;

   `ACS_ASSERT_ALWAYS(a_busy_not_ready, !(busy_ff && ready_ff), "busy and ready both set")
   `ACS_ASSERT_ALWAYS(a_counter_range, phase_counter_ff <= COUNT_W'(16), "phase counter overrun")
   `ACS_ASSERT_IMPLIES(a_idle_clean, !busy_ff,
      !stable_ff && phase_counter_ff == '0 && sum_ff == '0, "idle with stale sequence state")
   `ACS_ASSERT_NEXT(a_store_done, take && store_we,
      !busy_ff && ready_ff && rsp_valid_ff && busy_res_ff == 1'b0, "completion not reflected")

endmodule

`default_nettype wire
